>>> sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Transfer types, bank state, mapper mode codes and address constants.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int OFFSET_W = 20;

  // Access kinds carried by an input transfer.
  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_CTRL      = 2'd2,
    ACT_COLD_RST  = 2'd3
  } action_t;

  // Mapper mode codes; values above MODE_DUAL behave as MODE_NONE.
  localparam logic [3:0] MODE_NONE   = 4'd0;
  localparam logic [3:0] MODE_8K     = 4'd1;
  localparam logic [3:0] MODE_16K    = 4'd2;
  localparam logic [3:0] MODE_D32K   = 4'd3;
  localparam logic [3:0] MODE_D64K   = 4'd4;
  localparam logic [3:0] MODE_D128K  = 4'd5;
  localparam logic [3:0] MODE_A128K  = 4'd6;
  localparam logic [3:0] MODE_A1M    = 4'd7;
  localparam logic [3:0] MODE_512K   = 4'd8;
  localparam logic [3:0] MODE_MATH   = 4'd9;
  localparam logic [3:0] MODE_DUAL   = 4'd10;

  // Address decoding constants.
  localparam logic [15:0] HOT_MASK      = 16'hEFFF;
  localparam logic [15:0] HOT_FIRST     = 16'h8FF6;
  localparam logic [15:0] HOT_LAST      = 16'h8FF9;
  localparam logic [7:0]  CTRL_PAGE     = 8'hD5;
  localparam logic [15:0] A128_OFF_ADDR = 16'hD510;
  localparam logic [15:0] A128_IGN_ADDR = 16'hD520;
  localparam logic [15:0] A1M_OFF_ADDR  = 16'hD580;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic                rom_valid;
    logic [OFFSET_W-1:0] rom_offset;
    logic                remap;
    logic                handled;
    logic                bank_on;
    logic [6:0]          bank_now;
  } out_item_t;

  typedef struct packed {
    logic       primary_enable;
    logic [6:0] primary_bank;
    logic [1:0] second_bank;
  } bank_state_t;

  // Bank selected right after a mode load or a cold reset.
  function automatic logic [6:0] initial_bank(input logic [3:0] mode);
    logic [6:0] bank;
    case (mode)
      MODE_D32K:  bank = 7'd3;
      MODE_D64K:  bank = 7'd7;
      MODE_D128K: bank = 7'd15;
      MODE_A1M:   bank = 7'd127;
      default:    bank = 7'd0;
    endcase
    return bank;
  endfunction

  function automatic logic initial_enable(input logic [3:0] mode);
    return (mode >= MODE_8K) && (mode <= MODE_DUAL) && (mode != MODE_MATH);
  endfunction

endpackage

>>> sv/cbm_step.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper step
// Bank state update and ROM offset decode for one bus access.
// ----------------------------------------------------------------------------
module cbm_step
  import cbm_pkg::*;
#(
  parameter int ROM_ADDR_BITS = 20
) (
  input  logic [3:0]  mode,
  input  in_item_t    item,
  input  bank_state_t state,
  output bank_state_t state_next,
  output out_item_t   result
);

  localparam logic [OFFSET_W-1:0] OFFSET_MASK =
    OFFSET_W'((21'(1) << ROM_ADDR_BITS) - 21'(1));

  logic [15:0]         addr;
  logic [15:0]         hot_addr;
  logic                hot_hit;
  logic [1:0]          hot_idx;
  logic                in_window;
  logic                upper;
  logic [12:0]         lo;
  logic [OFFSET_W-1:0] off_8k;
  logic [OFFSET_W-1:0] off_16k;
  logic [OFFSET_W-1:0] off_4k;
  logic [OFFSET_W-1:0] off_second;
  logic [OFFSET_W-1:0] offset;
  logic                mapped;
  logic                ctrl_hit;
  bank_state_t         hot_state;
  bank_state_t         ctrl_state;
  logic                ctrl_handled;

  assign addr     = item.address;
  assign hot_addr = addr & HOT_MASK;
  assign hot_idx  = 2'(hot_addr[11:0] - HOT_FIRST[11:0]);
  assign hot_hit  = (mode == MODE_DUAL) && (hot_addr >= HOT_FIRST) && (hot_addr <= HOT_LAST);

  // Dual-bank hot addresses switch a half's bank before the read is served.
  always_comb begin
    hot_state = state;
    if (hot_hit) begin
      if (addr[12]) begin
        hot_state.second_bank = hot_idx;
      end else begin
        hot_state.primary_bank = {5'd0, hot_idx};
      end
    end
  end

  // Control page writes select or disable the primary bank.
  assign ctrl_hit = (addr[15:8] == CTRL_PAGE);

  always_comb begin
    ctrl_state   = state;
    ctrl_handled = 1'b0;
    if (ctrl_hit) begin
      case (mode)
        MODE_D32K: begin
          ctrl_state.primary_bank = {5'd0, item.data[1:0]};
          ctrl_handled = 1'b1;
        end
        MODE_D64K: begin
          ctrl_state.primary_bank = {4'd0, item.data[2:0]};
          ctrl_handled = 1'b1;
        end
        MODE_D128K: begin
          ctrl_state.primary_bank = {3'd0, item.data[3:0]};
          ctrl_handled = 1'b1;
        end
        MODE_A128K: begin
          ctrl_handled = 1'b1;
          if (addr < A128_OFF_ADDR) begin
            ctrl_state.primary_bank   = {3'd0, addr[3:0]};
            ctrl_state.primary_enable = 1'b1;
          end else if (addr < A128_IGN_ADDR) begin
            ctrl_state.primary_enable = 1'b0;
          end
        end
        MODE_A1M: begin
          ctrl_handled = 1'b1;
          if (addr < A1M_OFF_ADDR) begin
            ctrl_state.primary_bank   = addr[6:0];
            ctrl_state.primary_enable = 1'b1;
          end else begin
            ctrl_state.primary_enable = 1'b0;
          end
        end
        MODE_512K: begin
          ctrl_handled = 1'b1;
          if (item.data[7]) begin
            ctrl_state.primary_enable = 1'b0;
          end else begin
            ctrl_state.primary_bank   = {2'd0, item.data[4:0]};
            ctrl_state.primary_enable = 1'b1;
          end
        end
        default: begin
          ctrl_handled = 1'b0;
        end
      endcase
    end
  end

  // Window read decode, using the banks after any hot-address switch.
  assign in_window  = (addr[15:14] == 2'b10);
  assign upper      = addr[13];
  assign lo         = addr[12:0];
  assign off_8k     = {hot_state.primary_bank, 13'd0};
  assign off_16k    = {hot_state.primary_bank[5:0], 14'd0};
  assign off_4k     = {1'b0, hot_state.primary_bank, 12'd0};
  assign off_second = {5'd0, 1'b1, hot_state.second_bank, 12'd0};

  always_comb begin
    mapped = 1'b1;
    offset = '0;
    case (mode)
      MODE_8K: begin
        mapped = upper;
        offset = {7'd0, lo};
      end
      MODE_16K:   offset = upper ? (20'h02000 + {7'd0, lo}) : (off_8k + {7'd0, lo});
      MODE_D32K:  offset = upper ? (20'h06000 + {7'd0, lo}) : (off_8k + {7'd0, lo});
      MODE_D64K:  offset = upper ? (20'h0E000 + {7'd0, lo}) : (off_8k + {7'd0, lo});
      MODE_D128K: offset = upper ? (20'h1E000 + {7'd0, lo}) : (off_8k + {7'd0, lo});
      MODE_A128K, MODE_A1M: begin
        mapped = upper;
        offset = off_8k + {7'd0, lo};
      end
      MODE_512K: offset = off_16k + (upper ? 20'h02000 : 20'h00000) + {7'd0, lo};
      MODE_DUAL: begin
        if (upper) begin
          offset = 20'h08000 + {7'd0, lo};
        end else if (!addr[12]) begin
          offset = off_4k + {8'd0, addr[11:0]};
        end else begin
          offset = off_second + {8'd0, addr[11:0]};
        end
      end
      default: mapped = 1'b0;
    endcase
    if (!in_window || !state.primary_enable) begin
      mapped = 1'b0;
    end
  end

  // Select the next state and the result fields by access kind.
  always_comb begin
    state_next        = state;
    result            = '0;
    case (item.action)
      ACT_READ: begin
        state_next        = hot_state;
        result.remap      = hot_hit;
        result.rom_valid  = mapped;
        result.rom_offset = mapped ? (offset & OFFSET_MASK) : '0;
      end
      ACT_WRITE: begin
        state_next     = hot_state;
        result.remap   = hot_hit;
        result.handled = hot_hit;
      end
      ACT_CTRL: begin
        state_next     = ctrl_state;
        result.handled = ctrl_handled;
      end
      default: begin
        state_next.primary_bank   = initial_bank(mode);
        state_next.primary_enable = initial_enable(mode);
      end
    endcase
    result.bank_on  = state_next.primary_enable;
    result.bank_now = state_next.primary_bank;
  end

endmodule

>>> sv/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Bank-switching mapper for a cartridge ROM seen in the 0x8000-0xBFFF window.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer on in_valid/in_ready carries one CPU bus access
// (window read, window write, control page write or cold reset). Each one
// produces exactly one result transfer on out_valid/out_ready with the ROM
// offset, the mapped flag, remap and handled flags and the bank after the
// access. An access enters an input register, the bank update and offset
// decode run in the following cycle, and the result lands in an output
// register. While the receiver keeps out_ready high, one access per
// cycle is sustained; the rate is set by the single decode stage between
// the two registers. When the receiver stalls, the input register still
// takes one more access, then in_ready drops until the result moves on.
// cfg_we writes mode from cfg_data and reloads that mode's initial
// bank; write it only while no access is in flight. Reset empties both
// registers and selects mode none with the bank disabled.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core
  import cbm_pkg::*;
#(
  parameter int ROM_ADDR_BITS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  logic        s1_valid;
  in_item_t    s1_item;
  logic        advance;
  logic [3:0]  mode;
  bank_state_t state;
  bank_state_t state_next;
  out_item_t   result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  cbm_step #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_step (
    .mode       (mode),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // Mode register and bank state; a mode write reloads the initial bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= MODE_NONE;
      state.primary_enable <= initial_enable(MODE_NONE);
      state.primary_bank   <= initial_bank(MODE_NONE);
      state.second_bank    <= 2'd0;
    end else if (cfg_we) begin
      mode                 <= cfg_data;
      state.primary_enable <= initial_enable(cfg_data);
      state.primary_bank   <= initial_bank(cfg_data);
      state.second_bank    <= 2'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  // A mapped read always comes from an enabled bank.
  a_mapped_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.rom_valid |-> out_item.bank_on)
    else $error("mapped read reported with bank disabled");

  // Hot addresses only exist in dual-bank mode, where the primary bank stays small.
  a_remap_bank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.remap |-> (out_item.bank_now <= 7'd3))
    else $error("remap reported with a primary bank above 3");

  // An access held in the input register is not dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register lost an access during a stall");

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");
`endif

endmodule
